### hdl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine
`timescale 1ns / 1ps

package i2cm_pkg;

    // default counter widths
    localparam int DELAY_WIDTH_DEF   = 16;
    localparam int STRETCH_WIDTH_DEF = 16;

    // configuration register indexes and reset values
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STRETCH_LIMIT = 2'd1;
    localparam logic [15:0] HALF_PERIOD_RESET   = 16'd100;
    localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;

    // raw command codes on the input port
    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_START = 3'd1;
    localparam logic [2:0] CODE_STOP  = 3'd2;
    localparam logic [2:0] CODE_WRITE = 3'd3;
    localparam logic [2:0] CODE_READ  = 3'd4;

    // bit slot that carries the acknowledge
    localparam logic [3:0] ACK_SLOT = 4'd8;

    // classified command
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_kind_t;

    // engine phase
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_RS_D1,
        PH_RS_W,
        PH_RS_D2,
        PH_ST_D,
        PH_SP_D1,
        PH_SP_W,
        PH_SP_D2,
        PH_SP_D3,
        PH_B_D1,
        PH_B_W,
        PH_B_D2
    } phase_t;

    // one queued tick
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
        logic       scl_in;
    } item_t;

    // one result beat
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       stretch_timeout;
        logic       bus_open;
    } result_t;

endpackage

### hdl/i2cm_front.sv
// Front end: accepts tick beats, classifies the command, two-entry queue
`timescale 1ns / 1ps

module i2cm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic [7:0]          tx_byte,
    input  logic                ack_to_send,
    input  logic                sda_in,
    input  logic                scl_in,
    output logic                q_valid,
    output i2cm_pkg::item_t     q_item,
    input  logic                q_pop
);

    i2cm_pkg::item_t item_in;
    i2cm_pkg::item_t ent_reg [2];
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic            push;

    // command classification, unknown codes act as none
    always_comb
    begin
        case (command)
            i2cm_pkg::CODE_START: item_in.kind = i2cm_pkg::CMD_START;
            i2cm_pkg::CODE_STOP:  item_in.kind = i2cm_pkg::CMD_STOP;
            i2cm_pkg::CODE_WRITE: item_in.kind = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::CODE_READ:  item_in.kind = i2cm_pkg::CMD_READ;
            default:              item_in.kind = i2cm_pkg::CMD_NONE;
        endcase
        item_in.tx_byte     = tx_byte;
        item_in.ack_to_send = ack_to_send;
        item_in.sda_in      = sda_in;
        item_in.scl_in      = scl_in;
    end

    // handshake and queue pointers
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### hdl/i2cm_back.sv
// Back end: bit timing engine, one queued tick per unstalled cycle, registered result
`timescale 1ns / 1ps

module i2cm_back
#(
    parameter int DELAY_WIDTH   = i2cm_pkg::DELAY_WIDTH_DEF,
    parameter int STRETCH_WIDTH = i2cm_pkg::STRETCH_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         half_period,
    input  logic [15:0]         stretch_limit,
    input  logic                q_valid,
    input  i2cm_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cm_pkg::result_t   res
);

    i2cm_pkg::phase_t    phase_reg, phase_next;
    i2cm_pkg::cmd_kind_t cmd_reg, cmd_next;
    logic [3:0]               bit_cnt_reg, bit_cnt_next;
    logic [7:0]               shifter_reg, shifter_next;
    logic [DELAY_WIDTH-1:0]   delay_cnt_reg, delay_cnt_next;
    logic [STRETCH_WIDTH-1:0] stretch_cnt_reg, stretch_cnt_next;
    logic                     started_reg, started_next;
    logic                     ack_reg, ack_next;
    logic                     ack_out_reg, ack_out_next;
    logic [7:0]               rx_reg, rx_next;
    logic                     timeout_reg, timeout_next;
    logic                     scl_rel_reg, scl_rel_next;
    logic                     sda_rel_reg, sda_rel_next;
    logic                     done_next;
    logic                     out_valid_reg, out_valid_next;
    i2cm_pkg::result_t        res_reg, res_next;

    logic [DELAY_WIDTH-1:0]   delay_inc;
    logic [15:0]              half_eff;
    logic                     delay_more;
    logic                     stretch_more;
    logic                     is_write;
    logic                     bit_rd;
    logic [3:0]               bit_inc;
    logic                     rd_after;
    logic [7:0]               shift_end;
    logic                     sda_next_bit;

    // a tick is taken when the result slot is free or draining
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // half-bit delay and stretch wait conditions
    assign delay_inc    = delay_cnt_reg + DELAY_WIDTH'(1);
    assign half_eff     = (half_period == 16'd0) ? 16'd1 : half_period;
    assign delay_more   = (33'(delay_inc) < 33'(half_eff)) && (delay_inc != '1);
    assign stretch_more = (33'(stretch_cnt_reg) < 33'(stretch_limit))
                          && (stretch_cnt_reg != '1);

    // bit slot decode
    assign is_write = (cmd_reg == i2cm_pkg::CMD_WRITE);
    assign bit_rd   = is_write ? (bit_cnt_reg == i2cm_pkg::ACK_SLOT)
                               : (bit_cnt_reg <  i2cm_pkg::ACK_SLOT);
    assign bit_inc  = bit_cnt_reg + 4'd1;
    assign rd_after = is_write ? (bit_inc == i2cm_pkg::ACK_SLOT)
                               : (bit_inc <  i2cm_pkg::ACK_SLOT);

    // shift register at the end of a bit
    always_comb
    begin
        if (bit_rd)
        begin
            shift_end = (bit_cnt_reg == i2cm_pkg::ACK_SLOT) ? shifter_reg
                        : {shifter_reg[6:0], q_item.sda_in};
        end
        else if (is_write)
        begin
            shift_end = {shifter_reg[6:0], 1'b0};
        end
        else
        begin
            shift_end = shifter_reg;
        end
    end

    // sda level of the bit that follows
    assign sda_next_bit = rd_after ? 1'b1 : (is_write ? shift_end[7] : ack_out_reg);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        bit_cnt_next     = bit_cnt_reg;
        shifter_next     = shifter_reg;
        delay_cnt_next   = delay_cnt_reg;
        stretch_cnt_next = stretch_cnt_reg;
        started_next     = started_reg;
        ack_next         = ack_reg;
        ack_out_next     = ack_out_reg;
        rx_next          = rx_reg;
        timeout_next     = timeout_reg;
        scl_rel_next     = scl_rel_reg;
        sda_rel_next     = sda_rel_reg;
        done_next        = 1'b0;
        case (phase_reg)
            i2cm_pkg::PH_IDLE:
            begin
                if (q_item.kind != i2cm_pkg::CMD_NONE)
                begin
                    timeout_next   = 1'b0;
                    cmd_next       = q_item.kind;
                    delay_cnt_next = '0;
                    case (q_item.kind)
                        i2cm_pkg::CMD_START:
                        begin
                            sda_rel_next = started_reg;
                            phase_next   = started_reg ? i2cm_pkg::PH_RS_D1
                                                       : i2cm_pkg::PH_ST_D;
                        end
                        i2cm_pkg::CMD_STOP:
                        begin
                            sda_rel_next = 1'b0;
                            phase_next   = i2cm_pkg::PH_SP_D1;
                        end
                        i2cm_pkg::CMD_WRITE:
                        begin
                            shifter_next = q_item.tx_byte;
                            bit_cnt_next = 4'd0;
                            sda_rel_next = q_item.tx_byte[7];
                            phase_next   = i2cm_pkg::PH_B_D1;
                        end
                        default:
                        begin
                            shifter_next = 8'd0;
                            ack_out_next = q_item.ack_to_send;
                            bit_cnt_next = 4'd0;
                            sda_rel_next = 1'b1;
                            phase_next   = i2cm_pkg::PH_B_D1;
                        end
                    endcase
                end
            end
            i2cm_pkg::PH_RS_W, i2cm_pkg::PH_SP_W, i2cm_pkg::PH_B_W:
            begin
                if (!q_item.scl_in && stretch_more)
                begin
                    stretch_cnt_next = stretch_cnt_reg + STRETCH_WIDTH'(1);
                end
                else
                begin
                    if (!q_item.scl_in)
                    begin
                        timeout_next = 1'b1;
                    end
                    delay_cnt_next = '0;
                    case (phase_reg)
                        i2cm_pkg::PH_RS_W: phase_next = i2cm_pkg::PH_RS_D2;
                        i2cm_pkg::PH_SP_W: phase_next = i2cm_pkg::PH_SP_D2;
                        default:           phase_next = i2cm_pkg::PH_B_D2;
                    endcase
                end
            end
            default:
            begin
                if (delay_more)
                begin
                    delay_cnt_next = delay_inc;
                end
                else
                begin
                    delay_cnt_next = '0;
                    case (phase_reg)
                        i2cm_pkg::PH_RS_D1, i2cm_pkg::PH_SP_D1, i2cm_pkg::PH_B_D1:
                        begin
                            scl_rel_next     = 1'b1;
                            stretch_cnt_next = '0;
                            case (phase_reg)
                                i2cm_pkg::PH_RS_D1: phase_next = i2cm_pkg::PH_RS_W;
                                i2cm_pkg::PH_SP_D1: phase_next = i2cm_pkg::PH_SP_W;
                                default:            phase_next = i2cm_pkg::PH_B_W;
                            endcase
                        end
                        i2cm_pkg::PH_RS_D2:
                        begin
                            sda_rel_next = 1'b0;
                            phase_next   = i2cm_pkg::PH_ST_D;
                        end
                        i2cm_pkg::PH_ST_D:
                        begin
                            scl_rel_next = 1'b0;
                            started_next = 1'b1;
                            phase_next   = i2cm_pkg::PH_IDLE;
                            done_next    = 1'b1;
                            if (cmd_reg == i2cm_pkg::CMD_READ)
                            begin
                                rx_next = shifter_reg;
                            end
                        end
                        i2cm_pkg::PH_SP_D2:
                        begin
                            sda_rel_next = 1'b1;
                            phase_next   = i2cm_pkg::PH_SP_D3;
                        end
                        i2cm_pkg::PH_SP_D3:
                        begin
                            started_next = 1'b0;
                            phase_next   = i2cm_pkg::PH_IDLE;
                            done_next    = 1'b1;
                            if (cmd_reg == i2cm_pkg::CMD_READ)
                            begin
                                rx_next = shifter_reg;
                            end
                        end
                        i2cm_pkg::PH_B_D2:
                        begin
                            if (bit_rd && bit_cnt_reg == i2cm_pkg::ACK_SLOT)
                            begin
                                ack_next = q_item.sda_in;
                            end
                            shifter_next = shift_end;
                            scl_rel_next = 1'b0;
                            if (bit_cnt_reg >= i2cm_pkg::ACK_SLOT)
                            begin
                                phase_next = i2cm_pkg::PH_IDLE;
                                done_next  = 1'b1;
                                if (cmd_reg == i2cm_pkg::CMD_READ)
                                begin
                                    rx_next = shift_end;
                                end
                            end
                            else
                            begin
                                bit_cnt_next = bit_inc;
                                sda_rel_next = sda_next_bit;
                                phase_next   = i2cm_pkg::PH_B_D1;
                            end
                        end
                        default:
                        begin
                            phase_next = i2cm_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // result fields after this tick
    always_comb
    begin
        res_next.scl_release     = scl_rel_next;
        res_next.sda_release     = sda_rel_next;
        res_next.busy_res        = (phase_next != i2cm_pkg::PH_IDLE);
        res_next.done_res        = done_next;
        res_next.rx_byte         = rx_next;
        res_next.ack_received    = ack_next;
        res_next.stretch_timeout = timeout_next;
        res_next.bus_open        = started_next;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cm_pkg::PH_IDLE;
            cmd_reg         <= i2cm_pkg::CMD_NONE;
            bit_cnt_reg     <= 4'd0;
            shifter_reg     <= 8'd0;
            delay_cnt_reg   <= '0;
            stretch_cnt_reg <= '0;
            started_reg     <= 1'b0;
            ack_reg         <= 1'b0;
            ack_out_reg     <= 1'b0;
            rx_reg          <= 8'd0;
            timeout_reg     <= 1'b0;
            scl_rel_reg     <= 1'b1;
            sda_rel_reg     <= 1'b1;
        end
        else if (q_pop)
        begin
            phase_reg       <= phase_next;
            cmd_reg         <= cmd_next;
            bit_cnt_reg     <= bit_cnt_next;
            shifter_reg     <= shifter_next;
            delay_cnt_reg   <= delay_cnt_next;
            stretch_cnt_reg <= stretch_cnt_next;
            started_reg     <= started_next;
            ack_reg         <= ack_next;
            ack_out_reg     <= ack_out_next;
            rx_reg          <= rx_next;
            timeout_reg     <= timeout_next;
            scl_rel_reg     <= scl_rel_next;
            sda_rel_reg     <= sda_rel_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### hdl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: configuration registers and the two halves
`timescale 1ns / 1ps

// Each input beat is one tick of the bus timing: it carries an optional command
// (start, stop, write byte, read byte) and the sampled SDA and SCL levels, and
// yields exactly one result beat with the line drive levels and status after
// that tick. One beat is taken per clock cycle unless the result is stalled.
// With no backlog an accepted input beat is first written into the two-entry
// input queue, and the engine step that pops it then loads the output register
// that offers its result beat. The sustained rate is set by the engine step, an
// update of the phase machine with its half-bit delay counter and stretch counter.
// Commands arriving while a command is in progress are ignored. Configuration
// writes are held off while a tick beat is offered or waits in the input queue.
module i2c_master_bit_engine_core
#(
    parameter int DELAY_WIDTH   = i2cm_pkg::DELAY_WIDTH_DEF,
    parameter int STRETCH_WIDTH = i2cm_pkg::STRETCH_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [2:0]                            command,
    input  logic [7:0]                            tx_byte,
    input  logic                                  ack_to_send,
    input  logic                                  sda_in,
    input  logic                                  scl_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  scl_release,
    output logic                                  sda_release,
    output logic                                  busy_res,
    output logic                                  done_res,
    output logic [7:0]                            rx_byte,
    output logic                                  ack_received,
    output logic                                  stretch_timeout,
    output logic                                  bus_open,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [15:0]                           cfg_data
);

    logic [15:0]       half_period_reg, half_period_next;
    logic [15:0]       stretch_limit_reg, stretch_limit_next;
    logic              q_valid;
    logic              q_pop;
    i2cm_pkg::item_t   q_item;
    i2cm_pkg::result_t res;

    // configuration register writes, only with no tick beat pending
    assign cfg_ready = !q_valid && !in_valid;

    always_comb
    begin
        half_period_next   = half_period_reg;
        stretch_limit_next = stretch_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                i2cm_pkg::REG_HALF_PERIOD:   half_period_next   = cfg_data;
                i2cm_pkg::REG_STRETCH_LIMIT: stretch_limit_next = cfg_data;
                default:
                begin
                    half_period_next   = half_period_reg;
                    stretch_limit_next = stretch_limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= i2cm_pkg::HALF_PERIOD_RESET;
            stretch_limit_reg <= i2cm_pkg::STRETCH_LIMIT_RESET;
        end
        else
        begin
            half_period_reg   <= half_period_next;
            stretch_limit_reg <= stretch_limit_next;
        end
    end

    // input queue
    i2cm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .tx_byte     (tx_byte),
        .ack_to_send (ack_to_send),
        .sda_in      (sda_in),
        .scl_in      (scl_in),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // timing engine
    i2cm_back
    #(
        .DELAY_WIDTH   (DELAY_WIDTH),
        .STRETCH_WIDTH (STRETCH_WIDTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .half_period   (half_period_reg),
        .stretch_limit (stretch_limit_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .res           (res)
    );

    // result beat fields
    assign scl_release     = res.scl_release;
    assign sda_release     = res.sda_release;
    assign busy_res        = res.busy_res;
    assign done_res        = res.done_res;
    assign rx_byte         = res.rx_byte;
    assign ack_received    = res.ack_received;
    assign stretch_timeout = res.stretch_timeout;
    assign bus_open        = res.bus_open;

endmodule

### hdl/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level
`timescale 1ns / 1ps

module i2cm_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  scl_release,
    input  logic                                  sda_release,
    input  logic                                  busy_res,
    input  logic                                  done_res,
    input  logic [7:0]                            rx_byte,
    input  logic                                  ack_received,
    input  logic                                  stretch_timeout,
    input  logic                                  bus_open,
    input  logic                                  cfg_ready
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scl_release)
        && $stable(sda_release) && $stable(busy_res) && $stable(done_res)
        && $stable(rx_byte) && $stable(ack_received)
        && $stable(stretch_timeout) && $stable(bus_open))
        else $error("result beat changed while stalled");

    // a finished command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done pulse with engine still busy");

    // the input side only backs up behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without output stall");

    // a tick beat just taken holds configuration writes off
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !cfg_ready)
        else $error("configuration write open with a tick beat queued");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_i2cm_checker (.*);
